// File: rtl/core/kblq_pkg.sv
`timescale 1ns / 1ps

package kblq_pkg;

    // Action codes carried by an input beat.
    localparam logic [2:0] ACT_ASCII_PRESS = 3'd0;
    localparam logic [2:0] ACT_VKEY_PRESS  = 3'd1;
    localparam logic [2:0] ACT_DATA_READ   = 3'd2;
    localparam logic [2:0] ACT_FLAG_READ   = 3'd3;
    localparam logic [2:0] ACT_STROBE_CLR  = 3'd4;
    localparam logic [2:0] ACT_CAPS_TOGGLE = 3'd5;
    localparam logic [2:0] ACT_CAPS_SET    = 3'd6;

    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] VKEY_FIRST  = 8'h25;
    localparam logic [7:0] VKEY_LAST   = 8'h2E;
    localparam logic [7:0] STROBE_BIT  = 8'h80;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] key_value;
        logic       caps_value;
    } kblq_in_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [6:0] latch_value;
        logic       caps_on;
        logic [4:0] queue_level;
        logic       overflow;
    } kblq_out_t;

    // Cursor and delete codes for virtual keys 0x25..0x2E; zero means ignore.
    function automatic logic [7:0] vkey_code(input logic [3:0] idx);
        logic [7:0] code;
        unique case (idx)
            4'd0:    code = 8'h08;
            4'd1:    code = 8'h0B;
            4'd2:    code = 8'h15;
            4'd3:    code = 8'h0A;
            4'd9:    code = 8'h7F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/keyboard_latch_with_key_queue_core.sv
`timescale 1ns / 1ps

// Keyboard latch and strobe with a queue of pending key codes. Each input beat
// carries one action (ASCII press, virtual-key press, data read, flag read,
// strobe clear, caps toggle, caps set) and yields exactly one result beat with
// the read byte, the latch, caps lock, the queue level and a dropped-key flag.
// The block takes one beat per clock cycle unless out_ready holds results back;
// a beat passes the input register, then the result register, and the result
// register lets a new beat enter while a result waits for out_ready. The queue is
// a QUEUE_DEPTH x 8 memory with one write and one registered read port; the
// front entry is held in a register and the entry behind it is prefetched
// every cycle, so a pop never waits on the memory. Queue entries need no
// clearing after reset: an entry is read only after it has been written.
module keyboard_latch_with_key_queue_core
    import kblq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  kblq_in_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output kblq_out_t out_item
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    // Input stage.
    logic     stg_valid_reg;
    kblq_in_t stg_item_reg;
    logic     stg_fire;

    // Result stage.
    logic      out_valid_reg;
    kblq_out_t out_item_reg;
    kblq_out_t out_item_next;

    // Architectural state.
    logic [7:0]    latch_reg, latch_next;
    logic          caps_reg, caps_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    front_reg, front_next;

    // Queue memory and the prefetch of the entry behind the front.
    logic [7:0]    mem [QUEUE_DEPTH];
    logic          wr_en;
    logic [IW-1:0] rd_addr;
    logic [7:0]    mem_rd_reg;
    logic          byp_hit_reg;
    logic [7:0]    byp_data_reg;
    logic [7:0]    ahead;

    logic [7:0] code;
    logic [3:0] vidx;
    logic       press;
    logic       pop;
    logic       ovf;
    logic [7:0] rd_value;

    // Advance the input stage whenever the result register is free or drains.
    assign stg_fire  = stg_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stg_valid_reg || stg_fire;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // The prefetch may be one write behind; the bypass covers that write.
    assign ahead = byp_hit_reg ? byp_data_reg : mem_rd_reg;

    always_comb
    begin
        latch_next = latch_reg;
        caps_next  = caps_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        front_next = front_reg;
        code       = stg_item_reg.key_value;
        vidx       = 4'(stg_item_reg.key_value - VKEY_FIRST);
        press      = 1'b0;
        pop        = 1'b0;
        ovf        = 1'b0;
        wr_en      = 1'b0;
        rd_value   = 8'h00;

        if (stg_fire)
        begin
            unique case (stg_item_reg.action)
                ACT_ASCII_PRESS:
                begin
                    // Upper-case a..z while caps lock is on.
                    if (caps_reg && (code >= LOWER_A) && (code <= LOWER_Z))
                    begin
                        code = code - CASE_OFFSET;
                    end
                    latch_next = code;
                    press      = 1'b1;
                end
                ACT_VKEY_PRESS:
                begin
                    code = 8'h00;
                    if ((stg_item_reg.key_value >= VKEY_FIRST) &&
                        (stg_item_reg.key_value <= VKEY_LAST))
                    begin
                        code = vkey_code(vidx);
                    end
                    // Drop unmapped keys without touching anything.
                    if (code != 8'h00)
                    begin
                        latch_next = code;
                        press      = 1'b1;
                    end
                end
                ACT_DATA_READ, ACT_FLAG_READ:
                begin
                    if (count_reg != '0)
                    begin
                        latch_next = front_reg;
                        rd_value   = front_reg | STROBE_BIT;
                        pop        = (stg_item_reg.action == ACT_FLAG_READ);
                    end
                    else
                    begin
                        rd_value = latch_reg;
                    end
                end
                ACT_STROBE_CLR:
                begin
                    if (count_reg != '0)
                    begin
                        latch_next = front_reg;
                        rd_value   = front_reg | STROBE_BIT;
                        pop        = 1'b1;
                    end
                end
                ACT_CAPS_TOGGLE:
                begin
                    caps_next = !caps_reg;
                end
                ACT_CAPS_SET:
                begin
                    caps_next = stg_item_reg.caps_value;
                end
                default:
                begin
                end
            endcase
        end

        // Queue the pressed key, or drop it and flag overflow when full.
        if (press)
        begin
            if (count_reg == FULL_CNT)
            begin
                ovf = 1'b1;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
                if (count_reg == '0)
                begin
                    front_next = latch_next;
                end
            end
        end

        // Pop the front; the prefetched entry becomes the new front.
        if (pop)
        begin
            count_next = count_reg - CW'(1);
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
            if (count_reg > CW'(1))
            begin
                front_next = ahead;
            end
        end

        rd_addr = (head_next == LAST_IDX) ? '0 : head_next + IW'(1);

        out_item_next.read_value  = rd_value;
        out_item_next.latch_value = latch_next[6:0];
        out_item_next.caps_on     = caps_next;
        out_item_next.queue_level = 5'(count_next);
        out_item_next.overflow    = ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            latch_reg     <= 8'h00;
            caps_reg      <= 1'b1;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stg_valid_reg <= in_valid;
            end
            if (stg_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            latch_reg   <= latch_next;
            caps_reg    <= caps_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            byp_hit_reg <= wr_en && (tail_reg == rd_addr);
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_item_reg <= in_item;
        end
        if (stg_fire)
        begin
            out_item_reg <= out_item_next;
        end
        front_reg    <= front_next;
        byp_data_reg <= latch_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= latch_next;
        end
        mem_rd_reg <= mem[rd_addr];
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import kblq_pkg::*;

    localparam int KEY_DEPTH    = 16;
    localparam int RANDOM_BEATS = 1330;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Action code that the package leaves unassigned; the block must ignore it.
    localparam logic [2:0] ACT_SPARE = 3'd7;

    localparam logic [7:0] ASC_LOWER_A = 8'h61;
    localparam logic [7:0] ASC_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP    = 8'h20;
    localparam logic [7:0] CUR_FIRST   = 8'h25;
    localparam logic [7:0] CUR_LAST    = 8'h2E;
    localparam logic [7:0] READY_BIT   = 8'h80;

    // Cursor/delete translation for virtual keys CUR_FIRST..CUR_LAST; zero is ignored.
    localparam logic [7:0] CURSOR_CODES [10] = '{
        8'h08, 8'h0B, 8'h15, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F
    };

    typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_t;

    typedef struct {
        kblq_in_t  item;
        bit        typed;
        kblq_out_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    kblq_in_t  in_item;
    logic      out_valid;
    logic      out_ready;
    kblq_out_t out_item;

    // Hand-typed expectation riding along with the beat currently offered.
    logic      row_typed;
    kblq_out_t row_want;

    // Predictor state: latch, caps lock and the pending key queue.
    logic [7:0] kb_latch;
    logic       kb_caps;
    logic [7:0] pend_keys [KEY_DEPTH];
    int         pend_head;
    int         pend_count;

    kblq_out_t expected_q [$];
    dir_row_t  dir_rows [$];

    bit quiet;
    int errors;
    int beats_sent;
    int results_seen;
    int keys_dropped;
    int peak_level;
    int idle_cycles;

    keyboard_latch_with_key_queue_core #(
        .QUEUE_DEPTH(KEY_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Apply one action to the predictor state and return the result beat it yields.
    function automatic kblq_out_t advance_keyboard(input kblq_in_t it);
        kblq_out_t res;
        logic [7:0] key;
        logic [7:0] code;
        logic       pressed;
        res     = '0;
        key     = it.key_value;
        pressed = 1'b0;
        case (it.action)
            ACT_ASCII_PRESS:
            begin
                // Upper-case a..z only while caps lock is on.
                if (kb_caps && key >= ASC_LOWER_A && key <= ASC_LOWER_Z)
                    key = key - CASE_GAP;
                kb_latch = key;
                pressed  = 1'b1;
            end
            ACT_VKEY_PRESS:
            begin
                if (key >= CUR_FIRST && key <= CUR_LAST)
                begin
                    code = CURSOR_CODES[key - CUR_FIRST];
                    if (code != 8'h00)
                    begin
                        kb_latch = code;
                        pressed  = 1'b1;
                    end
                end
            end
            ACT_DATA_READ:
            begin
                if (pend_count != 0)
                begin
                    kb_latch       = pend_keys[pend_head];
                    res.read_value = kb_latch | READY_BIT;
                end
                else
                    res.read_value = kb_latch;
            end
            ACT_FLAG_READ:
            begin
                if (pend_count != 0)
                begin
                    kb_latch       = pend_keys[pend_head];
                    res.read_value = kb_latch | READY_BIT;
                    pend_head      = (pend_head + 1) % KEY_DEPTH;
                    pend_count--;
                end
                else
                    res.read_value = kb_latch;
            end
            ACT_STROBE_CLR:
            begin
                // Empty queue answers zero here, unlike the two reads.
                if (pend_count != 0)
                begin
                    kb_latch       = pend_keys[pend_head];
                    res.read_value = kb_latch | READY_BIT;
                    pend_head      = (pend_head + 1) % KEY_DEPTH;
                    pend_count--;
                end
            end
            ACT_CAPS_TOGGLE: kb_caps = ~kb_caps;
            ACT_CAPS_SET:    kb_caps = it.caps_value;
            default: ;
        endcase
        // A press into a full queue still loads the latch but drops the key.
        if (pressed)
        begin
            if (pend_count >= KEY_DEPTH)
                res.overflow = 1'b1;
            else
            begin
                pend_keys[(pend_head + pend_count) % KEY_DEPTH] = kb_latch;
                pend_count++;
            end
        end
        res.latch_value = kb_latch[6:0];
        res.caps_on     = kb_caps;
        res.queue_level = pend_count[4:0];
        return res;
    endfunction

    // At least half of the draws are back-to-back; quiet stretches force no idling at all.
    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Random beat shaped by the burst kind: fills push the queue past full,
    // drains pop it back to empty, mixes wander in between.
    function automatic kblq_in_t make_beat(input burst_t kind);
        kblq_in_t it;
        int press_pct;
        int roll;
        it.key_value  = 8'($urandom_range(0, 255));
        it.caps_value = 1'($urandom_range(0, 1));
        press_pct = (kind == BURST_FILL) ? 80 : (kind == BURST_DRAIN) ? 15 : 45;
        if ($urandom_range(0, 99) < press_pct)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                it.action = ACT_ASCII_PRESS;
                if ($urandom_range(0, 99) < 40)
                    it.key_value = 8'($urandom_range(ASC_LOWER_A, ASC_LOWER_Z));
            end
            else
            begin
                it.action = ACT_VKEY_PRESS;
                if ($urandom_range(0, 99) < 75)
                    it.key_value = 8'($urandom_range(CUR_FIRST, CUR_LAST));
            end
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 28)
                it.action = ACT_DATA_READ;
            else if (roll < 56)
                it.action = ACT_FLAG_READ;
            else if (roll < 84)
                it.action = ACT_STROBE_CLR;
            else if (roll < 91)
                it.action = ACT_CAPS_TOGGLE;
            else if (roll < 97)
                it.action = ACT_CAPS_SET;
            else
                it.action = ACT_SPARE;
        end
        return it;
    endfunction

    task automatic add_row(input logic [2:0] act, input logic [7:0] key, input logic cv,
                           input bit typed, input logic [7:0] rd, input logic [6:0] lat,
                           input logic cap, input logic [4:0] lvl, input logic ovf);
        dir_row_t row;
        row.item  = '{action: act, key_value: key, caps_value: cv};
        row.typed = typed;
        row.want  = '{read_value: rd, latch_value: lat, caps_on: cap,
                      queue_level: lvl, overflow: ovf};
        dir_rows.push_back(row);
    endtask

    // Offer one beat after a random gap and hold it until the block takes it.
    // Entered and left at a falling edge.
    task automatic send_beat(input kblq_in_t it, input bit typed, input kblq_out_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_item   <= it;
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        @(negedge clk);
    endtask

    // Scoreboard: predict on every accepted input beat, check every accepted
    // result beat against the oldest prediction.
    always @(posedge clk)
    begin : scoreboard
        kblq_out_t want;
        kblq_out_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = advance_keyboard(in_item);
                // Rows with a typed answer still advance the predictor.
                if (row_typed)
                    want = row_want;
                expected_q.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = out_item;
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0h, got %0h",
                               want.read_value, got.read_value);
                        errors++;
                    end
                    if (got.latch_value !== want.latch_value)
                    begin
                        $error("latch_value: expected %0h, got %0h",
                               want.latch_value, got.latch_value);
                        errors++;
                    end
                    if (got.caps_on !== want.caps_on)
                    begin
                        $error("caps_on: expected %0b, got %0b", want.caps_on, got.caps_on);
                        errors++;
                    end
                    if (got.queue_level !== want.queue_level)
                    begin
                        $error("queue_level: expected %0d, got %0d",
                               want.queue_level, got.queue_level);
                        errors++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                        errors++;
                    end
                    if (want.overflow)
                        keys_dropped++;
                    if (int'(want.queue_level) > peak_level)
                        peak_level = int'(want.queue_level);
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result sink: stall a random number of cycles, then take one beat.
    initial
    begin : sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        burst_t kind;
        int     burst_len;
        int     sent;
        bit     paused;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        quiet        = 1'b0;
        errors       = 0;
        beats_sent   = 0;
        results_seen = 0;
        keys_dropped = 0;
        peak_level   = 0;
        idle_cycles  = 0;
        kb_latch     = 8'h00;
        kb_caps      = 1'b1;
        pend_head    = 0;
        pend_count   = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows. Typed answers where they follow directly from reset,
        // the byte extremes and the read/pop order; the rest use the predictor.
        //      action           key    cv    typed rd     latch  caps lvl   ovf
        add_row(ACT_DATA_READ,   8'h00, 1'b0, 1, 8'h00, 7'h00, 1'b1, 5'd0, 1'b0);
        add_row(ACT_STROBE_CLR,  8'h00, 1'b0, 1, 8'h00, 7'h00, 1'b1, 5'd0, 1'b0);
        add_row(ACT_FLAG_READ,   8'h00, 1'b0, 1, 8'h00, 7'h00, 1'b1, 5'd0, 1'b0);
        add_row(ACT_SPARE,       8'hFF, 1'b1, 1, 8'h00, 7'h00, 1'b1, 5'd0, 1'b0);
        add_row(ACT_ASCII_PRESS, 8'h61, 1'b0, 1, 8'h00, 7'h41, 1'b1, 5'd1, 1'b0);
        add_row(ACT_CAPS_TOGGLE, 8'h00, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_ASCII_PRESS, 8'h7A, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        // Latch with bit 7 set: all 8 bits kept, only 7 shown.
        add_row(ACT_ASCII_PRESS, 8'hFF, 1'b0, 1, 8'h00, 7'h7F, 1'b0, 5'd3, 1'b0);
        add_row(ACT_VKEY_PRESS,  8'h25, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        // Virtual key mapping to a zero entry: ignored.
        add_row(ACT_VKEY_PRESS,  8'h29, 1'b1, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_VKEY_PRESS,  8'h2E, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_VKEY_PRESS,  8'h24, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_VKEY_PRESS,  8'h2F, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_CAPS_SET,    8'h00, 1'b1, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_ASCII_PRESS, 8'h00, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_DATA_READ,   8'hFF, 1'b1, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_FLAG_READ,   8'h00, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_STROBE_CLR,  8'h00, 1'b0, 1, 8'hFA, 7'h7A, 1'b1, 5'd4, 1'b0);
        add_row(ACT_FLAG_READ,   8'h00, 1'b0, 1, 8'hFF, 7'h7F, 1'b1, 5'd3, 1'b0);
        add_row(ACT_CAPS_SET,    8'hFF, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_ASCII_PRESS, 8'h6D, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_CAPS_TOGGLE, 8'h00, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        // Just outside a..z: never case-shifted.
        add_row(ACT_ASCII_PRESS, 8'h60, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);
        add_row(ACT_ASCII_PRESS, 8'h7B, 1'b0, 0, 8'h00, 7'h00, 1'b0, 5'd0, 1'b0);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // Random bursts; one pause midway lets every result drain first.
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_BEATS)
        begin
            kind      = burst_t'($urandom_range(0, 2));
            burst_len = $urandom_range(4, 40);
            quiet     = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst_len && sent < RANDOM_BEATS; k++)
            begin
                send_beat(make_beat(kind), 1'b0, '0);
                sent++;
            end
            if (!paused && sent >= RANDOM_BEATS / 2)
            begin
                // Hold the sender until nothing is outstanding.
                in_valid <= 1'b0;
                while (expected_q.size() != 0)
                    @(negedge clk);
                paused = 1'b1;
            end
        end
        in_valid <= 1'b0;
        quiet     = 1'b0;

        // Drain: wait for the last results, then a few cycles for strays.
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d beats (%0d directed), %0d results checked.",
                 beats_sent, dir_rows.size(), results_seen);
        $display("Keys dropped on a full queue: %0d, peak queue level: %0d.",
                 keys_dropped, peak_level);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/kblq_pkg.sv
rtl/core/keyboard_latch_with_key_queue_core.sv
bench/tb.sv
